### rtl/assert_macros.svh
// Assertion macros for the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication checked outside reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/fmul_pkg.sv
package fmul_pkg;
    localparam int ExpW  = 8;
    localparam int MantW = 23;
    localparam int SigW  = MantW + 1;
    localparam logic [ExpW-1:0] ExpMax  = 8'hFF;
    localparam logic [9:0]      ExpBias = 10'd127;

    // Operand classes found in the first stage.
    localparam logic [1:0] CLS_NORMAL = 2'd0;
    localparam logic [1:0] CLS_ZERO   = 2'd1;
    localparam logic [1:0] CLS_INF    = 2'd2;

    // Values carried from the decode stage to the multiply stage.
    typedef struct packed {
        logic            sign;
        logic [1:0]      cls;
        logic [9:0]      exp;
        logic [SigW-1:0] sig_a;
        logic [SigW-1:0] sig_b;
    } dec_t;

    // Values carried from the multiply stage to the pack stage.
    typedef struct packed {
        logic            sign;
        logic [1:0]      cls;
        logic [9:0]      exp;
        logic [2*SigW-1:0] prod;
    } mul_t;
endpackage

### rtl/float32_multiply_truncating.sv
// Channel | Signals                                | Direction
// in      | in_valid, in_stall, a_bits, b_bits     | into block
// out     | out_valid, out_stall, product_bits,    | out of block
//         | overflow, underflow                    |
// Three register stages: decode, 24x24 multiply, pack. One transaction is
// taken every cycle while the output moves.
// Reset clears the stage valid bits only. A stall at the output freezes
// every stage that holds data; empty stages still fill (bubbles collapse).
module float32_multiply_truncating
    import fmul_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [31:0] a_bits,
    input  logic [31:0] b_bits,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [31:0] product_bits,
    output logic        overflow,
    output logic        underflow
);
`include "assert_macros.svh"

    dec_t        dec_next;
    dec_t        dec_reg;
    mul_t        mul_reg;
    logic [31:0] prod_reg;
    logic        ovf_reg;
    logic        unf_reg;
    logic [31:0] prod_next;
    logic        ovf_next;
    logic        unf_next;
    logic        v1_reg;
    logic        v2_reg;
    logic        v3_reg;
    logic        en3;
    logic        en2;
    logic        en1;

    // Each stage advances when the stage after it is empty or moving.
    assign en3 = !v3_reg || !out_stall;
    assign en2 = !v2_reg || en3;
    assign en1 = !v1_reg || en2;
    assign in_stall = !en1;

    fmul_decode u_dec (.a_bits(a_bits), .b_bits(b_bits), .dec(dec_next));

    fmul_pack u_pack (
        .mul(mul_reg), .product_bits(prod_next),
        .overflow(ovf_next), .underflow(unf_next)
    );

    // Valid bits.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (en1) v1_reg <= in_valid;
            if (en2) v2_reg <= v1_reg;
            if (en3) v3_reg <= v2_reg;
        end
    end

    // Payload stages; the multiplier sits between stage one and two.
    always_ff @(posedge clk)
    begin
        if (en1) dec_reg <= dec_next;
        if (en2)
        begin
            mul_reg.sign <= dec_reg.sign;
            mul_reg.cls  <= dec_reg.cls;
            mul_reg.exp  <= dec_reg.exp;
            mul_reg.prod <= dec_reg.sig_a * dec_reg.sig_b;
        end
        if (en3)
        begin
            prod_reg <= prod_next;
            ovf_reg  <= ovf_next;
            unf_reg  <= unf_next;
        end
    end

    assign out_valid    = v3_reg;
    assign product_bits = prod_reg;
    assign overflow     = ovf_reg;
    assign underflow    = unf_reg;

    `ASSERT_IMPL(a_flags_excl, clk, rst_n, out_valid, !(overflow && underflow), "both flags set")
    `ASSERT_NEXT(a_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(product_bits), "output lost under stall")
    `ASSERT_NEXT(a_fill, clk, rst_n, in_valid && !in_stall, v1_reg, "accepted transaction not captured")
endmodule

### rtl/fmul_decode.sv
module fmul_decode
    import fmul_pkg::*;
(
    input  logic [31:0] a_bits,
    input  logic [31:0] b_bits,
    output dec_t        dec
);
    logic [ExpW-1:0] ea;
    logic [ExpW-1:0] eb;

    // Split fields and classify; the exponent sum carries a sign bit.
    always_comb
    begin
        ea = a_bits[30:23];
        eb = b_bits[30:23];
        dec.sign  = a_bits[31] ^ b_bits[31];
        dec.sig_a = {1'b1, a_bits[MantW-1:0]};
        dec.sig_b = {1'b1, b_bits[MantW-1:0]};
        dec.exp   = {2'b00, ea} + {2'b00, eb} - ExpBias;
        if (ea == '0 || eb == '0)
        begin
            dec.cls = CLS_ZERO;
        end
        else if (ea == ExpMax || eb == ExpMax)
        begin
            dec.cls = CLS_INF;
        end
        else
        begin
            dec.cls = CLS_NORMAL;
        end
    end
endmodule

### rtl/fmul_pack.sv
module fmul_pack
    import fmul_pkg::*;
(
    input  mul_t        mul,
    output logic [31:0] product_bits,
    output logic        overflow,
    output logic        underflow
);
    logic [SigW:0] shifted;
    logic [9:0]    exp_n;
    logic          sat;
    logic          flush;

    // Drop 23 bits, normalize by one place, then range-check the exponent.
    always_comb
    begin
        shifted = mul.prod[2*SigW-1:MantW];
        exp_n   = mul.exp;
        if (shifted[SigW])
        begin
            shifted = shifted >> 1;
            exp_n   = exp_n + 10'd1;
        end
        sat   = !exp_n[9] && (exp_n[8:0] >= {1'b0, ExpMax});
        flush = exp_n[9] || (exp_n == '0);
        product_bits = {mul.sign, exp_n[ExpW-1:0], shifted[MantW-1:0]};
        overflow  = 1'b0;
        underflow = 1'b0;
        unique case (mul.cls)
            CLS_ZERO:
            begin
                product_bits = {mul.sign, 31'd0};
            end
            CLS_INF:
            begin
                product_bits = {mul.sign, ExpMax, 23'd0};
                overflow = 1'b1;
            end
            default:
            begin
                if (sat)
                begin
                    product_bits = {mul.sign, ExpMax, 23'd0};
                    overflow = 1'b1;
                end
                else if (flush)
                begin
                    product_bits = {mul.sign, 31'd0};
                    underflow = 1'b1;
                end
            end
        endcase
    end
endmodule

### dv/float32_multiply_truncating_tb.sv
module float32_multiply_truncating_tb;
    import fmul_pkg::*;

    localparam int WatchdogLimit = 5000;
    localparam int RandomItems   = 650;

    // One expected product with its exception flags.
    typedef struct packed {
        logic [31:0] bits;
        logic        ovf;
        logic        unf;
    } fmul_result_t;

    // Keeps the products still owed by the block and compares arrivals.
    class product_scoreboard;
        fmul_result_t pending[$];
        int errors;
        int checked;
        int n_ovf;
        int n_unf;

        // Truncating single-precision product of two bit patterns.
        function fmul_result_t multiply(logic [31:0] a, logic [31:0] b);
            fmul_result_t r;
            logic         sgn;
            logic [7:0]   ea;
            logic [7:0]   eb;
            logic [47:0]  full;
            logic [24:0]  sig;
            int           e;
            sgn = a[31] ^ b[31];
            ea = a[30:23];
            eb = b[30:23];
            r = '0;
            r.bits[31] = sgn;
            if (ea == 8'd0 || eb == 8'd0)
            begin
                return r;
            end
            if (ea == ExpMax || eb == ExpMax)
            begin
                r.bits[30:23] = ExpMax;
                r.ovf = 1'b1;
                return r;
            end
            full = {24'd0, 1'b1, a[22:0]} * {24'd0, 1'b1, b[22:0]};
            sig = full[47:23];
            e = int'(ea) + int'(eb) - 127;
            if (sig[24])
            begin
                sig = sig >> 1;
                e = e + 1;
            end
            if (e >= 255)
            begin
                r.bits[30:23] = ExpMax;
                r.ovf = 1'b1;
            end
            else if (e <= 0)
            begin
                r.unf = 1'b1;
            end
            else
            begin
                r.bits[30:23] = e[7:0];
                r.bits[22:0] = sig[22:0];
            end
            return r;
        endfunction

        // Records the expected product for an accepted operand pair.
        function void note_operands(logic [31:0] a, logic [31:0] b);
            pending.push_back(multiply(a, b));
        endfunction

        // Compares a delivered product with the oldest expectation.
        function void check_product(logic [31:0] bits, logic ovf, logic unf);
            fmul_result_t want;
            if (pending.size() == 0)
            begin
                $display("%0t: unexpected product %h ovf=%b unf=%b", $time, bits, ovf, unf);
                errors++;
                return;
            end
            want = pending.pop_front();
            checked++;
            if (want.ovf) n_ovf++;
            if (want.unf) n_unf++;
            if (bits !== want.bits)
            begin
                $display("%0t: product_bits expected %h actual %h", $time, want.bits, bits);
                errors++;
            end
            if (ovf !== want.ovf)
            begin
                $display("%0t: overflow expected %b actual %b", $time, want.ovf, ovf);
                errors++;
            end
            if (unf !== want.unf)
            begin
                $display("%0t: underflow expected %b actual %b", $time, want.unf, unf);
                errors++;
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [31:0] a_bits;
    logic [31:0] b_bits;
    logic        out_valid;
    logic        out_stall;
    logic [31:0] product_bits;
    logic        overflow;
    logic        underflow;

    product_scoreboard sb;
    bit quiet_phase;
    bit hold_long;
    int idle_cycles;

    float32_multiply_truncating dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .a_bits       (a_bits),
        .b_bits       (b_bits),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .product_bits (product_bits),
        .overflow     (overflow),
        .underflow    (underflow)
    );

    // Free-running clock.
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Random operand with an exponent drawn near the interesting bands.
    function automatic logic [31:0] rand_operand();
        logic [7:0] e;
        case ($urandom_range(0, 9))
            0: e = 8'd0;
            1: e = 8'hFF;
            2: e = 8'($urandom_range(1, 20));
            3: e = 8'($urandom_range(230, 254));
            default: e = 8'($urandom_range(64, 190));
        endcase
        return {1'($urandom()), e, 23'($urandom())};
    endfunction

    // Offers one operand pair, after an optional idle gap, and waits until the block takes it.
    // The valid stays high afterwards so pairs can follow back to back.
    task automatic send_pair(logic [31:0] a, logic [31:0] b, bit gaps);
        int gap;
        if (gaps && !quiet_phase && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 9);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        a_bits <= a;
        b_bits <= b;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        sb.note_operands(a, b);
    endtask

    // Receiver stall pattern: random bursts, one long hold-off, none at the end.
    initial
    begin
        int n;
        out_stall = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_long)
            begin
                out_stall <= 1'b1;
                repeat (40) @(posedge clk);
                out_stall <= 1'b0;
                hold_long = 1'b0;
            end
            else if (!quiet_phase && $urandom_range(0, 4) == 0)
            begin
                n = $urandom_range(1, 9);
                out_stall <= 1'b1;
                repeat (n) @(posedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    // Output monitor and watchdog on accepted transactions.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall)
                sb.check_product(product_bits, overflow, underflow);
            if ((out_valid && !out_stall) || (in_valid && !in_stall))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WatchdogLimit)
            begin
                $display("float32_multiply_truncating regression: fail");
                $finish;
            end
        end
    end

    // Stimulus.
    initial
    begin
        logic [31:0] dir_a[$];
        logic [31:0] dir_b[$];
        int waited;
        sb = new();
        quiet_phase = 1'b0;
        hold_long = 1'b0;
        idle_cycles = 0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        a_bits = '0;
        b_bits = '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed corners: zeros, subnormals, infinities, NaN, overflow,
        // underflow, normalization shift, extreme mantissas and signs.
        dir_a = '{32'h0000_0000, 32'h8000_0000, 32'h0000_0001, 32'h3F80_0000,
                  32'h7F80_0000, 32'h7FC0_0001, 32'h3F80_0000, 32'hBF80_0000,
                  32'h3FFF_FFFF, 32'h7F7F_FFFF, 32'h7F00_0000, 32'h0080_0000,
                  32'h0080_0000, 32'h3F00_0000, 32'h4000_0000, 32'hFFFF_FFFF,
                  32'h0000_0000, 32'h7F80_0000, 32'h3FC0_0000, 32'h4F00_0000};
        dir_b = '{32'h3F80_0000, 32'h7F80_0000, 32'h7F80_0000, 32'h3F80_0000,
                  32'h3F80_0000, 32'h3F80_0000, 32'hBF80_0000, 32'hBF80_0000,
                  32'h3FFF_FFFF, 32'h7F7F_FFFF, 32'h4000_0000, 32'h0080_0000,
                  32'h3F00_0000, 32'h0080_0000, 32'h3FFF_FFFF, 32'hFFFF_FFFF,
                  32'h0000_0000, 32'h0000_0000, 32'h3FC0_0000, 32'h2F80_0000};
        foreach (dir_a[i])
            send_pair(dir_a[i], dir_b[i], 1'b0);

        // Long receiver hold-off while operands keep coming.
        hold_long = 1'b1;
        for (int i = 0; i < 30; i++)
            send_pair(rand_operand(), rand_operand(), 1'b0);

        // Sender pauses until the block has drained.
        in_valid <= 1'b0;
        waited = 0;
        while (sb.pending.size() != 0 && waited < WatchdogLimit)
        begin
            @(posedge clk);
            waited++;
        end

        for (int i = 0; i < RandomItems; i++)
        begin
            if (i == RandomItems - 100)
                quiet_phase = 1'b1;
            send_pair(rand_operand(), rand_operand(), 1'b1);
        end

        in_valid <= 1'b0;
        waited = 0;
        while (sb.pending.size() != 0 && waited < WatchdogLimit)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (10) @(posedge clk);

        $display("Checked %0d products, %0d overflowing and %0d underflowing,",
                 sb.checked, sb.n_ovf, sb.n_unf);
        $display("under random sender gaps and receiver stalls.");
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("float32_multiply_truncating regression: pass");
        else
            $display("float32_multiply_truncating regression: fail");
        $finish;
    end
endmodule
